// ===== src/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Request and status codes shared by the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Request codes carried on the operation field.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    localparam int unsigned DATA_W = 32;

endpackage

// ===== src/bounded_deque_with_search_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top
// Double-ended queue of signed 32-bit values held in a ring memory, with a
// front-to-back membership search.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid, o_stall, i_operation, i_value_in) takes one
// transaction at a time; the result channel (o_valid, i_stall, o_value_out,
// o_found, o_is_empty, o_status) returns exactly one result per request.
// Pushes and rejected requests finish in the accept cycle, so their result
// is valid on the next cycle. A pop reads the ring memory through its
// registered read port; the read data then passes into the output register.
// A search walks the occupied entries front to back, one memory read per
// cycle, and stops at the first match or after the last occupied entry.
// A new request is taken once the previous one has finished and its result
// has left the output register or leaves it in the same cycle.
// While the receiver stalls, the result is held unchanged in the output
// register. Reset empties the queue (front index and occupancy go to zero);
// the ring memory itself is not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value_in,
    // Result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value_out,
    output logic               o_found,
    output logic               o_is_empty,
    output logic [1:0]         o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = bdq_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SEARCH
    } t_state;

    // Ring index that lies a given sum of places past position zero.
    function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
        logic [SW-1:0] lim;
        lim = SW'(DEPTH);
        if (s >= lim) begin
            return AW'(s - lim);
        end
        return AW'(s);
    endfunction

    // Next ring index, wrapping at the end of the ring.
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Previous ring index, wrapping at the start of the ring.
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        if (p == '0) begin
            return AW'(DEPTH - 1);
        end
        return p - 1'b1;
    endfunction

    // Ring memory with one write port and one registered read port.
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_value_in;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    // Control and output registers.
    t_state        r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_occ, n_occ;
    logic [DW-1:0] r_key, n_key;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_cmp_valid, n_cmp_valid;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_value_out, n_value_out;
    logic          r_found, n_found;
    logic          r_is_empty, n_is_empty;
    logic [1:0]    r_status, n_status;

    logic          accept;
    logic          is_full;
    logic          is_empty_now;
    logic [SW-1:0] back_sum;
    logic [CW-1:0] occ_inc;
    logic [CW-1:0] occ_dec;

    // A new request waits for the current one and for room in the output register.
    assign o_stall      = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept       = i_valid && !o_stall;
    assign is_full      = (r_occ == CW'(DEPTH));
    assign is_empty_now = (r_occ == '0);
    assign back_sum     = SW'(r_front) + SW'(r_occ);
    assign occ_inc      = r_occ + 1'b1;
    assign occ_dec      = r_occ - 1'b1;

    // Request decoding, pop completion and the search walk.
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_key       = r_key;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_cmp_valid = 1'b0;
        n_out_valid = r_out_valid;
        n_value_out = r_value_out;
        n_found     = r_found;
        n_is_empty  = r_is_empty;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = ring_dec(r_front);
        mem_raddr   = r_addr;

        // The result register drains when the receiver takes the transaction.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key       = i_value_in;
                    n_value_out = '0;
                    n_found     = 1'b0;
                    n_status    = bdq_pkg::ST_OK;
                    n_is_empty  = is_empty_now;
                    case (i_operation)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_status = bdq_pkg::ST_PUSH_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = ring_dec(r_front);
                                n_front    = ring_dec(r_front);
                                n_occ      = occ_inc;
                                n_is_empty = 1'b0;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_status = bdq_pkg::ST_PUSH_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = wrap_sum(back_sum);
                                n_occ      = occ_inc;
                                n_is_empty = 1'b0;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (is_empty_now) begin
                                n_out_valid = 1'b1;
                                n_status    = bdq_pkg::ST_POP_EMPTY;
                            end else begin
                                mem_raddr = r_front;
                                n_front   = ring_inc(r_front);
                                n_occ     = occ_dec;
                                n_state   = S_POP_WAIT;
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (is_empty_now) begin
                                n_out_valid = 1'b1;
                                n_status    = bdq_pkg::ST_POP_EMPTY;
                            end else begin
                                mem_raddr = wrap_sum(back_sum - 1'b1);
                                n_occ     = occ_dec;
                                n_state   = S_POP_WAIT;
                            end
                        end
                        bdq_pkg::OP_SEARCH: begin
                            n_idx   = '0;
                            n_addr  = r_front;
                            n_state = S_SEARCH;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Read data of the popped entry is available now.
            S_POP_WAIT: begin
                n_out_valid = 1'b1;
                n_value_out = r_mem_q;
                n_is_empty  = is_empty_now;
                n_state     = S_IDLE;
            end

            // Issue one read per cycle and compare the entry read in the previous cycle.
            S_SEARCH: begin
                mem_raddr = r_addr;
                if (r_cmp_valid && (r_mem_q == r_key)) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_is_empty  = is_empty_now;
                    n_state     = S_IDLE;
                end else if (r_idx < r_occ) begin
                    n_idx       = r_idx + 1'b1;
                    n_addr      = ring_inc(r_addr);
                    n_cmp_valid = 1'b1;
                end else if (!r_cmp_valid) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_is_empty  = is_empty_now;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_addr      <= n_addr;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_key       <= n_key;
        r_value_out <= n_value_out;
        r_found     <= n_found;
        r_is_empty  <= n_is_empty;
        r_status    <= n_status;
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_found     = r_found;
    assign o_is_empty  = r_is_empty;
    assign o_status    = r_status;

endmodule
